@@ rtl/raf_pkg.sv @@
package raf_pkg;

	localparam int MAX_WINDOW_DEF   = 16;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 3;
	localparam int WLOG_W     = 3;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOG2 = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_MODE  = 2'd1;

	localparam logic [WLOG_W-1:0] WLOG_RESET = 3'd3;
	localparam logic [WLOG_W-1:0] WLOG_MIN   = 3'd2;
	localparam logic [WLOG_W-1:0] WLOG_MAX   = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREFILL,
		ST_UPDATE,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DONE
	} raf_state_t;

endpackage

@@ rtl/raf_history.sv @@
module raf_history #(
	parameter int DEPTH = raf_pkg::MAX_WINDOW_DEF,
	parameter int WIDTH = raf_pkg::SAMPLE_WIDTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             clr,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] slot_q  [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rdata_q;

	// registered read, data appears the cycle after the address
	assign rdata = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clr) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			slot_q[waddr] <= wdata;
		end
		// an entry never written since the last clear reads as zero
		rdata_q <= valid_q[raddr] ? slot_q[raddr] : '0;
	end

endmodule

@@ rtl/raf_divider.sv @@
module raf_divider #(
	parameter int DIVIDEND_W = 20,
	parameter int DIVISOR_W  = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    trial;
	logic                  fits;
	logic [DIVISOR_W:0]    diff;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		fits  = trial >= {1'b0, divisor};
		diff  = trial - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/running_average_filter_unit.sv @@
// running average (boxcar) filter over the last 4, 8 or 16 samples
//
// input stream s_*: one unsigned sample per beat, low bits of s_tdata
// output stream m_*: one result beat per input beat, the truncated mean of
//   the window and a flag that says the window counts as full
// config port: cfg_we / cfg_index / cfg_wdata, register 0 window_log2,
//   register 1 start_mode; a write to either clears the history, total,
//   write slot and full flag, other indexes are ignored; write only while idle
//
// one sample at a time: s_tready is low from acceptance until the result is
// loaded into the output register. a sample goes through accept, an update
// step, a step to launch the divide, then the serial divider with one
// quotient bit per cycle for each bit of the running total (20 by default)
// and its done flag, and a final step to load the result. when prefilling on
// the first sample the update step becomes a pass that writes every window
// slot. the output register holds one result; if the receiver stalls, the
// next sample is still taken and its result waits in the final state until
// the output register frees up.
// reset clears the history valid bits at once, no clearing pass is needed
module running_average_filter_unit #(
	parameter int MAX_WINDOW   = raf_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = raf_pkg::SAMPLE_WIDTH_DEF,
	localparam int IN_W  = ((SAMPLE_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((SAMPLE_WIDTH + 1 + 7) / 8) * 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [IN_W-1:0]                s_tdata,   // sample
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [OUT_W-1:0]               m_tdata,   // average, window_full
	input  logic                           cfg_we,
	input  logic [raf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [raf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	import raf_pkg::*;

	localparam int SLOT_W = $clog2(MAX_WINDOW);
	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	// total of up to MAX_WINDOW samples
	localparam int TOT_W  = SAMPLE_WIDTH + SLOT_W;

	raf_state_t state_q, state_d;

	logic [WLOG_W-1:0]       wlog_q;
	logic                    mode_q;
	logic [SLOT_W-1:0]       slot_q;
	logic [SLOT_W-1:0]       idx_q;
	logic [TOT_W-1:0]        total_q;
	logic                    full_q;
	logic [CNT_W-1:0]        divisor_q;
	logic [SAMPLE_WIDTH-1:0] sample_q;
	logic                    m_valid_q;
	logic [SAMPLE_WIDTH-1:0] avg_q;
	logic                    wfull_q;

	logic [WLOG_W-1:0]       wlog_c;
	logic [4:0]              pow_len;
	logic [CNT_W-1:0]        win_len;

	logic                    cfg_hit;
	logic                    accept;
	logic                    out_free;
	logic [CNT_W-1:0]        slot_inc;
	logic                    slot_wrap;
	logic [CNT_W-1:0]        idx_inc;
	logic                    idx_last;
	logic [TOT_W-1:0]        total_upd;
	logic [TOT_W-1:0]        total_fill;

	logic                    hist_we;
	logic [SLOT_W-1:0]       hist_waddr;
	logic [SAMPLE_WIDTH-1:0] hist_rdata;
	logic                    div_start;
	logic                    div_done;
	logic [TOT_W-1:0]        quotient;
	logic                    out_load;

	// window length: clamp the log to 2..4, then cap at MAX_WINDOW
	always_comb begin
		if (wlog_q < WLOG_MIN) begin
			wlog_c = WLOG_MIN;
		end else if (wlog_q > WLOG_MAX) begin
			wlog_c = WLOG_MAX;
		end else begin
			wlog_c = wlog_q;
		end
		pow_len = 5'd1 << wlog_c;
		if (32'(pow_len) > MAX_WINDOW) begin
			win_len = CNT_W'(MAX_WINDOW);
		end else begin
			win_len = CNT_W'(pow_len);
		end
	end

	assign cfg_hit  = cfg_we && (cfg_index == REG_WINDOW_LOG2 ||
		cfg_index == REG_START_MODE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign slot_inc  = CNT_W'(slot_q) + CNT_W'(1);
	assign slot_wrap = slot_inc == win_len;
	assign idx_inc   = CNT_W'(idx_q) + CNT_W'(1);
	assign idx_last  = idx_inc == win_len;

	// drop the oldest sample, add the new one; oldest read at the accept edge
	assign total_upd  = total_q - TOT_W'(hist_rdata) + TOT_W'(sample_q);
	// prefill builds sample times window length one slot at a time
	assign total_fill = ((idx_q == '0) ? '0 : total_q) + TOT_W'(sample_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (mode_q && !full_q) ? ST_PREFILL : ST_UPDATE;
				end
			end
			ST_PREFILL: begin
				if (idx_last) begin
					state_d = ST_DIV_GO;
				end
			end
			ST_UPDATE:   state_d = ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready   = 1'b0;
		hist_we    = 1'b0;
		hist_waddr = slot_q;
		div_start  = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE:    s_tready = 1'b1;
			ST_PREFILL: begin
				hist_we    = 1'b1;
				hist_waddr = idx_q;
			end
			ST_UPDATE:  hist_we = 1'b1;
			ST_DIV_GO:  div_start = 1'b1;
			ST_DONE:    out_load = out_free;
			default:    s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wlog_q    <= WLOG_RESET;
			mode_q    <= 1'b0;
			slot_q    <= '0;
			idx_q     <= '0;
			total_q   <= '0;
			full_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_hit) begin
				if (cfg_index == REG_WINDOW_LOG2) begin
					wlog_q <= cfg_wdata[WLOG_W-1:0];
				end else begin
					mode_q <= cfg_wdata[0];
				end
				slot_q  <= '0;
				total_q <= '0;
				full_q  <= 1'b0;
			end

			if (accept) begin
				idx_q <= '0;
			end

			if (state_q == ST_PREFILL) begin
				total_q <= total_fill;
				idx_q   <= idx_inc[SLOT_W-1:0];
				if (idx_last) begin
					full_q <= 1'b1;
					slot_q <= SLOT_W'(1);
				end
			end

			if (state_q == ST_UPDATE) begin
				total_q <= total_upd;
				if (slot_wrap) begin
					slot_q <= '0;
					full_q <= 1'b1;
				end else begin
					slot_q <= slot_inc[SLOT_W-1:0];
				end
			end

			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_tdata[SAMPLE_WIDTH-1:0];
		end
		if (state_q == ST_PREFILL && idx_last) begin
			divisor_q <= win_len;
		end
		if (state_q == ST_UPDATE) begin
			// divide by samples seen until the ring has wrapped once
			divisor_q <= (full_q || slot_wrap) ? win_len : slot_inc;
		end
		if (out_load) begin
			avg_q   <= quotient[SAMPLE_WIDTH-1:0];
			wfull_q <= full_q;
		end
	end

	raf_history #(
		.DEPTH (MAX_WINDOW),
		.WIDTH (SAMPLE_WIDTH)
	) u_history (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (cfg_hit),
		.we     (hist_we),
		.waddr  (hist_waddr),
		.wdata  (sample_q),
		.raddr  (slot_q),
		.rdata  (hist_rdata)
	);

	raf_divider #(
		.DIVIDEND_W (TOT_W),
		.DIVISOR_W  (CNT_W)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (total_q),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_W'({wfull_q, avg_q});

endmodule

@@ rtl/raf_checker.sv @@
module raf_checker #(
	parameter int OUT_W = 24
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [OUT_W-1:0]               m_tdata,
	input logic                           cfg_we,
	input logic [raf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [raf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	logic s_beat;

	assign s_beat = s_tvalid && s_tready;

	// one sample in flight: busy right after a beat is taken
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |=> !s_tready)
		else $error("input taken while previous sample still in work");

	// a fresh result cannot follow a beat at once, the divide lies between them
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_beat |=> !$rose(m_tvalid) ##1 !$rose(m_tvalid))
		else $error("result appeared too soon after an input beat");

	// a new result is loaded only as the block returns to idle
	a_result_with_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result loaded while block still busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output beat changed");

	// register writes land only while the block is idle, with known values
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> s_tready && !$isunknown({cfg_index, cfg_wdata}))
		else $error("register write while busy or with unknown bits");

endmodule

bind running_average_filter_unit raf_checker #(
	.OUT_W (OUT_W)
) u_raf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_wdata (cfg_wdata)
);
